// ===== src/ccbd_pkg.sv =====
// Shared types, address map constants and target codes for the CPU bus decoder.
package ccbd_pkg;

    localparam int RAM_BYTES = 2048;
    localparam int RAM_AW    = $clog2(RAM_BYTES);

    localparam logic [2:0] TGT_RAM  = 3'd0;
    localparam logic [2:0] TGT_PIC  = 3'd1;
    localparam logic [2:0] TGT_DMA  = 3'd2;
    localparam logic [2:0] TGT_PAD  = 3'd3;
    localparam logic [2:0] TGT_AIO  = 3'd4;
    localparam logic [2:0] TGT_CART = 3'd5;
    localparam logic [2:0] TGT_NONE = 3'd6;

    localparam logic [15:0] ADDR_PIC_BASE  = 16'h2000;
    localparam logic [15:0] ADDR_IO_BASE   = 16'h4000;
    localparam logic [15:0] ADDR_DMA       = 16'h4014;
    localparam logic [15:0] ADDR_PAD_ONE   = 16'h4016;
    localparam logic [15:0] ADDR_PAD_TWO   = 16'h4017;
    localparam logic [15:0] ADDR_IO_END    = 16'h4020;
    localparam logic [15:0] ADDR_CART_BASE = 16'h6000;
    localparam logic [15:0] PIC_REG_MASK   = 16'h0007;
    localparam logic [7:0]  PAD_OPEN_BUS   = 8'h40;
    localparam logic [3:0]  PAD_COUNT_MAX  = 4'd8;

    typedef struct packed {
        logic        action;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [7:0]  pad_one_buttons;
        logic [7:0]  pad_two_buttons;
    } bus_req_t;

    typedef struct packed {
        logic [2:0]  target;
        logic [15:0] unit_address;
        logic [7:0]  unit_data;
        logic [7:0]  read_data;
    } bus_rsp_t;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } ccbd_state_t;

endpackage

// ===== src/console_cpu_bus_decoder_with_pads.sv =====
// Top level of the CPU bus decoder: memory map, work RAM and serial pad ports.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------
//  req     | in        | req_valid / req_ready  | ccbd_pkg::bus_req_t
//  rsp     | out       | rsp_valid / rsp_ready  | ccbd_pkg::bus_rsp_t
//
// One request accepted per cycle while the output is not stalled; its response
// passes the RAM read stage, then the output register; one response per request.
// After reset the work RAM is cleared one byte a cycle, all RAM_BYTES (2048)
// bytes, with req_ready low.
// A stalled response holds in the output register; one more request can
// advance into the RAM read stage behind it before req_ready drops.
module console_cpu_bus_decoder_with_pads (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  ccbd_pkg::bus_req_t req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output ccbd_pkg::bus_rsp_t rsp
);
    import ccbd_pkg::*;

    logic [7:0] work_ram [RAM_BYTES];

    ccbd_state_t       state_reg, state_next;
    logic [RAM_AW-1:0] clr_idx_reg;
    logic [7:0]        ram_rdata_reg;

    logic       strobe_reg, strobe_next;
    logic [7:0] pad_one_latch_reg, pad_one_latch_next;
    logic [7:0] pad_two_latch_reg, pad_two_latch_next;
    logic [3:0] pad_one_count_reg, pad_one_count_next;
    logic [3:0] pad_two_count_reg, pad_two_count_next;

    logic     s1_valid_reg;
    bus_rsp_t s1_rsp_reg;
    logic     s1_ram_rd_reg;
    logic     rsp_valid_reg;
    bus_rsp_t rsp_reg;

    logic              accept;
    logic              s1_move;
    logic              wr;
    logic [RAM_AW-1:0] ram_idx;
    logic              is_ram;
    logic              ram_we;
    bus_rsp_t          dec_rsp;
    logic              dec_ram_rd;
    logic [7:0]        pad_data;
    bus_rsp_t          s1_out;

    assign s1_move   = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == ST_RUN) && (!s1_valid_reg || s1_move);
    assign accept    = req_valid && req_ready;
    assign wr        = req.action;
    assign ram_idx   = req.address[RAM_AW-1:0];
    assign is_ram    = req.address < ADDR_PIC_BASE;
    assign ram_we    = accept && is_ram && wr;

    always_comb
    begin
        dec_rsp              = '0;
        dec_rsp.unit_address = req.address;
        dec_rsp.unit_data    = wr ? req.write_data : 8'h00;
        dec_ram_rd           = 1'b0;
        pad_data             = 8'h00;
        strobe_next          = strobe_reg;
        pad_one_latch_next   = pad_one_latch_reg;
        pad_two_latch_next   = pad_two_latch_reg;
        pad_one_count_next   = pad_one_count_reg;
        pad_two_count_next   = pad_two_count_reg;

        if (is_ram)
        begin
            dec_rsp.target       = TGT_RAM;
            dec_rsp.unit_address = 16'(ram_idx);
            dec_ram_rd           = !wr;
        end
        else if (req.address < ADDR_IO_BASE)
        begin
            dec_rsp.target       = TGT_PIC;
            dec_rsp.unit_address = req.address & PIC_REG_MASK;
        end
        else if (req.address == ADDR_DMA && wr)
        begin
            dec_rsp.target = TGT_DMA;
        end
        else if (req.address == ADDR_PAD_ONE)
        begin
            dec_rsp.target = TGT_PAD;
            if (wr)
            begin
                strobe_next = req.write_data[0];
                if (strobe_reg && !req.write_data[0])
                begin
                    pad_one_latch_next = req.pad_one_buttons;
                    pad_two_latch_next = req.pad_two_buttons;
                    pad_one_count_next = 4'd0;
                    pad_two_count_next = 4'd0;
                end
            end
            else if (strobe_reg)
            begin
                pad_data = PAD_OPEN_BUS | {7'd0, req.pad_one_buttons[0]};
            end
            else if (pad_one_count_reg >= PAD_COUNT_MAX)
            begin
                pad_data           = PAD_OPEN_BUS;
                pad_one_count_next = PAD_COUNT_MAX;
            end
            else
            begin
                pad_data = PAD_OPEN_BUS
                         | {7'd0, pad_one_latch_reg[pad_one_count_reg[2:0]]};
                pad_one_count_next = pad_one_count_reg + 4'd1;
            end
        end
        else if (req.address == ADDR_PAD_TWO && !wr)
        begin
            dec_rsp.target = TGT_PAD;
            if (strobe_reg)
            begin
                pad_data = PAD_OPEN_BUS | {7'd0, req.pad_two_buttons[0]};
            end
            else if (pad_two_count_reg >= PAD_COUNT_MAX)
            begin
                pad_data           = PAD_OPEN_BUS;
                pad_two_count_next = PAD_COUNT_MAX;
            end
            else
            begin
                pad_data = PAD_OPEN_BUS
                         | {7'd0, pad_two_latch_reg[pad_two_count_reg[2:0]]};
                pad_two_count_next = pad_two_count_reg + 4'd1;
            end
        end
        else if (req.address < ADDR_IO_END)
        begin
            dec_rsp.target = TGT_AIO;
        end
        else if (req.address >= ADDR_CART_BASE)
        begin
            dec_rsp.target = TGT_CART;
        end
        else
        begin
            dec_rsp.target = TGT_NONE;
        end

        dec_rsp.read_data = pad_data;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_idx_reg == '1)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // work RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
        begin
            work_ram[clr_idx_reg] <= 8'h00;
        end
        else if (ram_we)
        begin
            work_ram[ram_idx] <= req.write_data;
        end
        if (accept)
        begin
            ram_rdata_reg <= work_ram[ram_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            clr_idx_reg       <= '0;
            strobe_reg        <= 1'b0;
            pad_one_latch_reg <= 8'h00;
            pad_two_latch_reg <= 8'h00;
            pad_one_count_reg <= 4'd0;
            pad_two_count_reg <= 4'd0;
            s1_valid_reg      <= 1'b0;
            rsp_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + RAM_AW'(1);
            end
            if (accept)
            begin
                strobe_reg        <= strobe_next;
                pad_one_latch_reg <= pad_one_latch_next;
                pad_two_latch_reg <= pad_two_latch_next;
                pad_one_count_reg <= pad_one_count_next;
                pad_two_count_reg <= pad_two_count_next;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                rsp_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_comb
    begin
        s1_out = s1_rsp_reg;
        if (s1_ram_rd_reg)
        begin
            s1_out.read_data = ram_rdata_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_rsp_reg    <= dec_rsp;
            s1_ram_rd_reg <= dec_ram_rd;
        end
        if (s1_move && s1_valid_reg)
        begin
            rsp_reg <= s1_out;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== src/ccbd_checker.sv =====
// Port-level checker for the CPU bus decoder and its bind to the top level.
module ccbd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input ccbd_pkg::bus_req_t req,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input ccbd_pkg::bus_rsp_t rsp
);
    import ccbd_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    a_rw_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.read_data != 8'h00 |-> rsp.unit_data == 8'h00)
        else $error("response carries both read and write data");

    a_pic_index: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.target == TGT_PIC |-> rsp.unit_address[15:3] == 13'd0)
        else $error("picture register index out of range");

    a_ram_index: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.target == TGT_RAM |-> 32'(rsp.unit_address) < RAM_BYTES)
        else $error("RAM index out of range");

    a_pad_bus: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.target == TGT_PAD && rsp.read_data != 8'h00
            |-> rsp.read_data[7:1] == PAD_OPEN_BUS[7:1])
        else $error("pad read byte malformed");

endmodule

bind console_cpu_bus_decoder_with_pads ccbd_checker u_ccbd_checker (.*);

// ===== dv/tb_console_cpu_bus_decoder_with_pads.sv =====
// Self-checking testbench for the CPU bus decoder: memory map, work RAM and pad ports.
`timescale 1ns / 1ps

module tb_console_cpu_bus_decoder_with_pads;

    import ccbd_pkg::*;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int RSP_HOLD_CYCLES = 64;
    localparam int TAIL_CYCLES     = 10;
    localparam int IDLE_PERCENT    = 22;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    bus_req_t req       = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    bus_rsp_t rsp;

    logic [7:0] shadow_ram [RAM_BYTES];
    logic [7:0] pad_latch [2];
    logic [3:0] pad_count [2];
    logic       strobe_high;

    bus_rsp_t expected_rsp_q [$];
    int       requests_sent    = 0;
    int       responses_seen   = 0;
    int       mismatch_count   = 0;
    int       cycle_count      = 0;
    logic     traffic_idle     = 1'b1;
    logic     rsp_hold_pending = 1'b0;

    console_cpu_bus_decoder_with_pads DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [7:0] shift_pad(input int port, input logic [7:0] live);
        logic bit_out;
        if (strobe_high)
            return PAD_OPEN_BUS | {7'd0, live[0]};
        if (pad_count[port] >= PAD_COUNT_MAX)
        begin
            pad_count[port] = PAD_COUNT_MAX;
            return PAD_OPEN_BUS;
        end
        bit_out = pad_latch[port][pad_count[port][2:0]];
        pad_count[port] = pad_count[port] + 4'd1;
        return PAD_OPEN_BUS | {7'd0, bit_out};
    endfunction

    function automatic bus_rsp_t decode_access(input bus_req_t r);
        bus_rsp_t   o;
        logic [7:0] rd;
        int         idx;
        o.target       = TGT_NONE;
        o.unit_address = r.address;
        rd             = 8'h00;
        if (r.address < ADDR_PIC_BASE)
        begin
            idx            = r.address % RAM_BYTES;
            o.target       = TGT_RAM;
            o.unit_address = 16'(idx);
            if (r.action == ACT_WRITE)
                shadow_ram[idx] = r.write_data;
            else
                rd = shadow_ram[idx];
        end
        else if (r.address < ADDR_IO_BASE)
        begin
            o.target       = TGT_PIC;
            o.unit_address = r.address & PIC_REG_MASK;
        end
        else if (r.address == ADDR_DMA && r.action == ACT_WRITE)
            o.target = TGT_DMA;
        else if (r.address == ADDR_PAD_ONE)
        begin
            o.target = TGT_PAD;
            if (r.action == ACT_WRITE)
            begin
                if (strobe_high && !r.write_data[0])
                begin
                    pad_latch[0] = r.pad_one_buttons;
                    pad_latch[1] = r.pad_two_buttons;
                    pad_count[0] = 4'd0;
                    pad_count[1] = 4'd0;
                end
                strobe_high = r.write_data[0];
            end
            else
                rd = shift_pad(0, r.pad_one_buttons);
        end
        else if (r.address == ADDR_PAD_TWO && r.action == ACT_READ)
        begin
            o.target = TGT_PAD;
            rd       = shift_pad(1, r.pad_two_buttons);
        end
        else if (r.address < ADDR_IO_END)
            o.target = TGT_AIO;
        else if (r.address >= ADDR_CART_BASE)
            o.target = TGT_CART;
        o.unit_data = (r.action == ACT_WRITE) ? r.write_data : 8'h00;
        o.read_data = (r.action == ACT_WRITE) ? 8'h00 : rd;
        return o;
    endfunction

    function automatic bus_req_t make_request(input logic act, input logic [15:0] addr,
                                               input logic [7:0] data);
        bus_req_t r;
        r.action          = act;
        r.address         = addr;
        r.write_data      = data;
        r.pad_one_buttons = 8'($urandom);
        r.pad_two_buttons = 8'($urandom);
        return r;
    endfunction

    function automatic logic [15:0] pick_address();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 15)
            return 16'($urandom_range(3) * RAM_BYTES + $urandom_range(31));
        if (sel < 30)
            return 16'($urandom_range(16'h1FFF));
        if (sel < 40)
            return 16'($urandom_range(16'h3FFF, 16'h2000));
        if (sel < 55)
            return 16'($urandom_range(16'h401F, 16'h4000));
        if (sel < 65)
            return $urandom_range(1) ? ADDR_PAD_TWO : ADDR_PAD_ONE;
        if (sel < 75)
            return 16'($urandom_range(16'h5FFF, 16'h4020));
        if (sel < 85)
            return 16'($urandom_range(16'hFFFF, 16'h6000));
        return 16'($urandom);
    endfunction

    task automatic send_request(input bus_req_t r);
        if (traffic_idle && $urandom_range(99) < IDLE_PERCENT)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        expected_rsp_q.push_back(decode_access(r));
        requests_sent++;
    endtask

    task automatic wait_for_drain();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_rsp_q.size() != 0);
    endtask

    task automatic pad_sequence();
        send_request(make_request(ACT_WRITE, ADDR_PAD_ONE, 8'($urandom) | 8'h01));
        if ($urandom_range(3) == 0)
            send_request(make_request(ACT_READ, $urandom_range(1) ? ADDR_PAD_TWO : ADDR_PAD_ONE,
                                      8'($urandom)));
        send_request(make_request(ACT_WRITE, ADDR_PAD_ONE, 8'($urandom) & 8'hFE));
        repeat ($urandom_range(12))
        begin
            if ($urandom_range(5) == 0)
                send_request(make_request(1'($urandom), pick_address(), 8'($urandom)));
            else
                send_request(make_request(ACT_READ,
                                          $urandom_range(1) ? ADDR_PAD_TWO : ADDR_PAD_ONE,
                                          8'($urandom)));
        end
    endtask

    task automatic test_ram_mirroring();
        send_request(make_request(ACT_WRITE, 16'h07FF, 8'hFF));
        send_request(make_request(ACT_READ, 16'h1FFF, 8'h00));
        send_request(make_request(ACT_READ, 16'h0800, 8'h00));
    endtask

    task automatic test_picture_registers();
        send_request(make_request(ACT_WRITE, ADDR_PIC_BASE, 8'hA5));
        send_request(make_request(ACT_READ, 16'h3FFF, 8'h00));
    endtask

    task automatic test_dma_and_io();
        send_request(make_request(ACT_WRITE, ADDR_DMA, 8'h02));
        send_request(make_request(ACT_READ, ADDR_DMA, 8'h00));
        send_request(make_request(ACT_WRITE, ADDR_PAD_TWO, 8'hC0));
    endtask

    task automatic test_open_bus_and_cart();
        send_request(make_request(ACT_READ, ADDR_IO_END, 8'h00));
        send_request(make_request(ACT_WRITE, 16'h5FFF, 8'h3C));
        send_request(make_request(ACT_READ, ADDR_CART_BASE, 8'h00));
        send_request(make_request(ACT_WRITE, 16'hFFFF, 8'h81));
    endtask

    task automatic test_pad_ports();
        send_request(make_request(ACT_WRITE, ADDR_PAD_ONE, 8'h01));
        send_request(make_request(ACT_READ, ADDR_PAD_ONE, 8'h00));
        send_request(make_request(ACT_WRITE, ADDR_PAD_ONE, 8'h00));
        repeat (9) send_request(make_request(ACT_READ, ADDR_PAD_ONE, 8'h00));
        send_request(make_request(ACT_READ, ADDR_PAD_TWO, 8'h00));
    endtask

    task automatic test_random_traffic(input int count);
        int start;
        start = requests_sent;
        while (requests_sent - start < count)
        begin
            if ($urandom_range(99) < 25)
                pad_sequence();
            else
                send_request(make_request(1'($urandom), pick_address(), 8'($urandom)));
        end
    endtask

    task automatic test_response_backpressure();
        rsp_hold_pending = 1'b1;
        test_random_traffic(24);
    endtask

    task automatic test_pause_and_drain();
        test_random_traffic(12);
        wait_for_drain();
        test_random_traffic(12);
    endtask

    task automatic test_unbroken_stream();
        traffic_idle = 1'b0;
        test_random_traffic(100);
        traffic_idle = 1'b1;
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rsp_hold_pending)
            begin
                rsp_hold_pending = 1'b0;
                rsp_ready <= 1'b0;
                repeat (RSP_HOLD_CYCLES) @(posedge clk);
            end
            else
                rsp_ready <= !(traffic_idle && $urandom_range(99) < IDLE_PERCENT);
        end
    end

    always @(posedge clk)
    begin : check_responses
        bus_rsp_t want;
        if (rsp_valid && rsp_ready)
        begin
            responses_seen++;
            if (expected_rsp_q.size() == 0)
            begin
                $display("%0t: unexpected response target=%0d addr=%h", $time,
                         rsp.target, rsp.unit_address);
                mismatch_count++;
            end
            else
            begin
                want = expected_rsp_q.pop_front();
                if (rsp.target !== want.target)
                begin
                    $display("%0t: target expected %0d actual %0d", $time,
                             want.target, rsp.target);
                    mismatch_count++;
                end
                if (rsp.unit_address !== want.unit_address)
                begin
                    $display("%0t: unit_address expected %h actual %h", $time,
                             want.unit_address, rsp.unit_address);
                    mismatch_count++;
                end
                if (rsp.unit_data !== want.unit_data)
                begin
                    $display("%0t: unit_data expected %h actual %h", $time,
                             want.unit_data, rsp.unit_data);
                    mismatch_count++;
                end
                if (rsp.read_data !== want.read_data)
                begin
                    $display("%0t: read_data expected %h actual %h", $time,
                             want.read_data, rsp.read_data);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        for (int i = 0; i < RAM_BYTES; i++)
            shadow_ram[i] = 8'h00;
        pad_latch[0] = 8'h00;
        pad_latch[1] = 8'h00;
        pad_count[0] = 4'd0;
        pad_count[1] = 4'd0;
        strobe_high  = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ram_mirroring();
        test_picture_registers();
        test_dma_and_io();
        test_open_bus_and_cart();
        test_pad_ports();
        test_random_traffic(150);
        test_response_backpressure();
        test_pause_and_drain();
        test_unbroken_stream();
        test_random_traffic(140);

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d bus requests, %0d responses checked: RAM mirrors, picture regs, DMA,",
                 requests_sent, responses_seen);
        $display("pad strobe/latch/shift saturation, I/O, cartridge and unmapped space.");
        if (mismatch_count == 0 && expected_rsp_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
